### design/gddrc_pkg.sv
// shared types and constants for the grid dda ray caster
package gddrc_pkg;

    localparam int MAP_COLS_DEF    = 32;
    localparam int MAP_ROWS_DEF    = 32;
    localparam int TILE_WIDTH_DEF  = 64;
    localparam int TILE_HEIGHT_DEF = 64;

    localparam logic [7:0]  WALL_CODE_RST = 8'd1;
    localparam logic [15:0] MAX_DIST_RST  = 16'd10000;

    localparam int LEN_W = 35;
    localparam int CRD_W = 20;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    localparam logic REG_WALL_CODE = 1'b0;
    localparam logic REG_MAX_DIST  = 1'b1;

    typedef struct packed {
        logic        start;
        logic        sqrt;
        logic [31:0] dvd;
        logic [15:0] dvs;
    } t_du_req;

endpackage

### design/gddrc_divsqrt.sv
// shared radix-2 divider and square root unit, one result bit per cycle
module gddrc_divsqrt import gddrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_du_req     i_req,
    output logic        o_done,
    output logic [30:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic        r_sqrt;
    logic [4:0]  r_cnt;
    logic [31:0] r_dvd;
    logic [15:0] r_dvs;
    logic [30:0] r_quo;
    logic [19:0] r_rem;

    logic [19:0] shifted;
    logic [19:0] trial;
    logic        ge;

    always_comb begin
        shifted = r_sqrt ? {r_rem[17:0], r_dvd[31:30]} : {r_rem[18:0], r_dvd[31]};
        trial   = r_sqrt ? {2'b00, r_quo[15:0], 2'b01} : {4'b0000, r_dvs};
        ge      = shifted >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.sqrt ? 5'd15 : 5'd30;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt;
            r_dvs  <= i_req.dvs;
            r_dvd  <= i_req.sqrt ? i_req.dvd : {i_req.dvd[30:0], 1'b0};
            r_quo  <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (shifted - trial) : shifted;
            r_quo <= {r_quo[29:0], ge};
            r_dvd <= r_sqrt ? {r_dvd[29:0], 2'b00} : {r_dvd[30:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### design/gddrc_mul.sv
// shared registered multiplier
module gddrc_mul import gddrc_pkg::*; (
    input  logic        i_clk,
    input  logic [16:0] i_a,
    input  logic [31:0] i_b,
    output logic [48:0] o_p
);

    logic [48:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 49'(i_a) * 49'(i_b);
    end

    assign o_p = r_p;

endmodule

### design/gddrc_tile_map.sv
// tile map memory with clearing pass after reset
module gddrc_tile_map import gddrc_pkg::*; #(
    parameter int DEPTH  = MAP_COLS_DEF * MAP_ROWS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    output logic              o_clearing
);

    logic [7:0]        mem [DEPTH];
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr;
    logic [7:0]        r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            if (r_clr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr] <= 8'd0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd;
    assign o_clearing = r_clearing;

endmodule

### design/grid_dda_ray_caster_core.sv
// grid dda ray caster top level: sequencer, walk datapath and ports
// tile write: written into the map when taken, no result
// cast: setup (16-step root, four 31-step divides, tile index by reciprocal), then a step and
// a tile read per pixel crossing, then the hit point and the result; zero direction skips the walk
// one item at a time; the walk length is set by max_distance and the map
// reset: synchronous; the tile map is cleared entry by entry after reset, no item taken until done
module grid_dda_ray_caster_core import gddrc_pkg::*; #(
    parameter int MAP_COLS    = MAP_COLS_DEF,
    parameter int MAP_ROWS    = MAP_ROWS_DEF,
    parameter int TILE_WIDTH  = TILE_WIDTH_DEF,
    parameter int TILE_HEIGHT = TILE_HEIGHT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // start_x, start_y, dir_x, dir_y, tile_col, tile_row, tile_value, zero pad
    input  logic [103:0] i_s_tdata,
    // req_type
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // hit_x, hit_y
    output logic [47:0]  o_m_tdata,
    // hit_wall
    output logic [0:0]   o_m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int DEPTH   = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OXW     = (TILE_WIDTH > 1) ? $clog2(TILE_WIDTH) : 1;
    localparam int OYW     = (TILE_HEIGHT > 1) ? $clog2(TILE_HEIGHT) : 1;
    localparam int OFFX    = TILE_WIDTH * ((32768 + TILE_WIDTH - 1) / TILE_WIDTH);
    localparam int OFFY    = TILE_HEIGHT * ((32768 + TILE_HEIGHT - 1) / TILE_HEIGHT);
    localparam int BIASX   = OFFX / TILE_WIDTH;
    localparam int BIASY   = OFFY / TILE_HEIGHT;
    localparam int KX      = 17 + OXW;
    localparam int KY      = 17 + OYW;
    localparam int MULX    = ((1 << KX) + TILE_WIDTH - 1) / TILE_WIDTH;
    localparam int MULY    = ((1 << KY) + TILE_HEIGHT - 1) / TILE_HEIGHT;

    typedef enum logic [21:0] {
        S_IDLE = 22'h000001,
        S_SQX  = 22'h000002,
        S_SQY  = 22'h000004,
        S_SQS  = 22'h000008,
        S_SQRT = 22'h000010,
        S_DNX  = 22'h000020,
        S_DNY  = 22'h000040,
        S_DUX  = 22'h000080,
        S_DUY  = 22'h000100,
        S_DCX  = 22'h000200,
        S_DCY  = 22'h000400,
        S_FX   = 22'h000800,
        S_FY   = 22'h001000,
        S_FL   = 22'h002000,
        S_STEP = 22'h004000,
        S_CHK  = 22'h008000,
        S_HXL  = 22'h010000,
        S_HXH  = 22'h020000,
        S_HYL  = 22'h040000,
        S_HYH  = 22'h080000,
        S_HYF  = 22'h100000,
        S_OUT  = 22'h200000
    } t_state;

    t_state r_state, n_state;
    t_du_req r_du, n_du;

    logic [7:0]  r_wall;
    logic [15:0] r_maxd;

    logic               r_m_tvalid;
    logic [47:0]        r_m_tdata;
    logic               r_m_tuser;

    logic signed [23:0] r_sx, r_sy;
    logic               r_dxneg, r_dyneg;
    logic [15:0]        r_dxm, r_dym;
    logic [31:0]        r_acc;
    logic [15:0]        r_len;
    logic [14:0]        r_nxm, r_nym;
    logic [31:0]        r_ux, r_uy;
    logic signed [CRD_W-1:0] r_cx, r_cy;
    logic [OXW-1:0]     r_ox;
    logic [OYW-1:0]     r_oy;
    logic [LEN_W-1:0]   r_lx, r_ly, r_dist;
    logic               r_found;
    logic               r_inmap;
    logic [48:0]        r_hacc;
    logic [23:0]        r_hx, r_hy;

    logic               s_acc;
    logic               m_acc;
    logic               cfg_wr;
    logic               clearing;
    logic               du_done;
    logic [30:0]        du_quo;
    logic [16:0]        mul_a;
    logic [31:0]        mul_b;
    logic [48:0]        mul_p;
    logic [7:0]         rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    logic signed [15:0] in_dx, in_dy;
    logic [4:0]         in_col, in_row;
    logic [31:0]        sq_sum;
    logic               nxneg, nyneg;
    logic [8:0]         part_x, part_y;
    logic [LEN_W-1:0]   limit;
    logic               take_x;
    logic signed [CRD_W-1:0] n_cx, n_cy;
    logic [OXW-1:0]     n_ox;
    logic [OYW-1:0]     n_oy;
    logic               n_inmap;
    logic               hit_now;
    logic [16:0]        bx_pix, by_pix;
    logic [31:0]        cqx, cqy;
    logic [31:0]        remx, remy;

    function automatic logic [23:0] f_end(input logic [23:0] s, input logic neg,
                                          input logic [50:0] mag);
        logic signed [51:0] v;
        logic signed [51:0] r;
        logic signed [31:0] e;
        v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        r = (v + 52'sd2097152) >>> 22;
        e = $signed({{8{s[23]}}, s}) + $signed(r[31:0]);
        if (e > 32'sd8388607) begin
            return 24'h7FFFFF;
        end else if (e < -32'sd8388608) begin
            return 24'h800000;
        end else begin
            return e[23:0];
        end
    endfunction

    assign in_dx  = i_s_tdata[63:48];
    assign in_dy  = i_s_tdata[79:64];
    assign in_col = i_s_tdata[84:80];
    assign in_row = i_s_tdata[89:85];

    assign o_s_tready = (r_state == S_IDLE) && !clearing;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = r_m_tvalid && i_m_tready;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign prdata     = (paddr[2] == REG_MAX_DIST) ? {16'd0, r_maxd} : {24'd0, r_wall};

    assign wr_en   = s_acc && (i_s_tuser[0] == REQ_WRITE) &&
                     ({27'd0, in_col} < MAP_COLS) && ({27'd0, in_row} < MAP_ROWS);
    assign wr_addr = ADDR_W'(in_row * MAP_COLS + in_col);

    assign sq_sum = r_acc + mul_p[31:0];
    assign nxneg  = r_dxneg && (r_nxm != 15'd0);
    assign nyneg  = r_dyneg && (r_nym != 15'd0);
    assign part_x = nxneg ? {1'b0, r_sx[7:0]} : 9'd256 - {1'b0, r_sx[7:0]};
    assign part_y = nyneg ? {1'b0, r_sy[7:0]} : 9'd256 - {1'b0, r_sy[7:0]};
    assign limit  = {3'b000, r_maxd, 16'd0};
    assign take_x = r_lx < r_ly;
    assign hit_now = r_inmap && (rd_data == r_wall);

    // start pixel biased positive, tile index by reciprocal multiply
    assign bx_pix = 17'({{16{r_sx[23]}}, r_sx[23:8]} + 32'(OFFX));
    assign by_pix = 17'({{16{r_sy[23]}}, r_sy[23:8]} + 32'(OFFY));
    assign cqx    = 32'(mul_p >> KX);
    assign cqy    = 32'(mul_p >> KY);
    assign remx   = 32'(bx_pix) - cqx * 32'(TILE_WIDTH);
    assign remy   = 32'(by_pix) - cqy * 32'(TILE_HEIGHT);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQX: begin
                mul_a = {1'b0, r_dxm};
                mul_b = {16'd0, r_dxm};
            end
            S_SQY: begin
                mul_a = {1'b0, r_dym};
                mul_b = {16'd0, r_dym};
            end
            S_DCX: begin
                mul_a = bx_pix;
                mul_b = 32'(MULX);
            end
            S_DCY: begin
                mul_a = by_pix;
                mul_b = 32'(MULY);
            end
            S_FX: begin
                mul_a = {8'd0, part_x};
                mul_b = r_ux;
            end
            S_FY: begin
                mul_a = {8'd0, part_y};
                mul_b = r_uy;
            end
            S_HXL: begin
                mul_a = {2'b00, r_nxm};
                mul_b = r_dist[31:0];
            end
            S_HXH: begin
                mul_a = {2'b00, r_nxm};
                mul_b = 32'(r_dist[LEN_W-1:32]);
            end
            S_HYL: begin
                mul_a = {2'b00, r_nym};
                mul_b = r_dist[31:0];
            end
            S_HYH: begin
                mul_a = {2'b00, r_nym};
                mul_b = 32'(r_dist[LEN_W-1:32]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next pixel position of the walk, kept as tile index and offset in tile
    always_comb begin
        n_cx = r_cx;
        n_ox = r_ox;
        n_cy = r_cy;
        n_oy = r_oy;
        if (take_x) begin
            if (nxneg) begin
                if (r_ox == '0) begin
                    n_ox = OXW'(TILE_WIDTH - 1);
                    n_cx = r_cx - 1'b1;
                end else begin
                    n_ox = r_ox - 1'b1;
                end
            end else begin
                if (r_ox == OXW'(TILE_WIDTH - 1)) begin
                    n_ox = '0;
                    n_cx = r_cx + 1'b1;
                end else begin
                    n_ox = r_ox + 1'b1;
                end
            end
        end else begin
            if (nyneg) begin
                if (r_oy == '0) begin
                    n_oy = OYW'(TILE_HEIGHT - 1);
                    n_cy = r_cy - 1'b1;
                end else begin
                    n_oy = r_oy - 1'b1;
                end
            end else begin
                if (r_oy == OYW'(TILE_HEIGHT - 1)) begin
                    n_oy = '0;
                    n_cy = r_cy + 1'b1;
                end else begin
                    n_oy = r_oy + 1'b1;
                end
            end
        end
        n_inmap = (n_cx >= 0) && (n_cx < $signed(CRD_W'(MAP_COLS))) &&
                  (n_cy >= 0) && (n_cy < $signed(CRD_W'(MAP_ROWS)));
    end

    assign rd_addr = ADDR_W'(n_cy[7:0] * MAP_COLS + n_cx[7:0]);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_du         = r_du;
        n_du.start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_acc && (i_s_tuser[0] == REQ_CAST)) begin
                    n_state = S_SQX;
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: n_state = S_SQS;
            S_SQS: begin
                if (sq_sum == 32'd0) begin
                    n_state = S_HXL;
                end else begin
                    n_du    = '{start: 1'b1, sqrt: 1'b1, dvd: sq_sum, dvs: 16'd0};
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (du_done) begin
                    n_du    = '{start: 1'b1, sqrt: 1'b0, dvd: {2'b00, r_dxm, 14'd0},
                                dvs: du_quo[15:0]};
                    n_state = S_DNX;
                end
            end
            S_DNX: begin
                if (du_done) begin
                    n_du    = '{start: 1'b1, sqrt: 1'b0, dvd: {2'b00, r_dym, 14'd0},
                                dvs: r_len};
                    n_state = S_DNY;
                end
            end
            S_DNY: begin
                if (du_done) begin
                    n_du    = '{start: 1'b1, sqrt: 1'b0, dvd: 32'h4000_0000,
                                dvs: (r_nxm == 15'd0) ? 16'd1 : {1'b0, r_nxm}};
                    n_state = S_DUX;
                end
            end
            S_DUX: begin
                if (du_done) begin
                    n_du    = '{start: 1'b1, sqrt: 1'b0, dvd: 32'h4000_0000,
                                dvs: (r_nym == 15'd0) ? 16'd1 : {1'b0, r_nym}};
                    n_state = S_DUY;
                end
            end
            S_DUY: begin
                if (du_done) begin
                    n_state = S_DCX;
                end
            end
            S_DCX: n_state = S_DCY;
            S_DCY: n_state = S_FX;
            S_FX: n_state = S_FY;
            S_FY: n_state = S_FL;
            S_FL: n_state = (r_maxd == 16'd0) ? S_HXL : S_STEP;
            S_STEP: n_state = S_CHK;
            S_CHK: begin
                if (hit_now || (r_dist >= limit)) begin
                    n_state = S_HXL;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_HXL: n_state = S_HXH;
            S_HXH: n_state = S_HYL;
            S_HYL: n_state = S_HYH;
            S_HYH: n_state = S_HYF;
            S_HYF: n_state = S_OUT;
            S_OUT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_du       <= '0;
            r_wall     <= WALL_CODE_RST;
            r_maxd     <= MAX_DIST_RST;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_du    <= n_du;
            if (cfg_wr) begin
                if (paddr[2] == REG_WALL_CODE) begin
                    r_wall <= pwdata[7:0];
                end else begin
                    r_maxd <= pwdata[15:0];
                end
            end
            if ((r_state == S_OUT) && (!r_m_tvalid || i_m_tready)) begin
                r_m_tvalid <= 1'b1;
            end else if (m_acc) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sx    <= i_s_tdata[23:0];
                r_sy    <= i_s_tdata[47:24];
                r_dxneg <= in_dx[15];
                r_dyneg <= in_dy[15];
                r_dxm   <= in_dx[15] ? 16'(-in_dx) : in_dx;
                r_dym   <= in_dy[15] ? 16'(-in_dy) : in_dy;
            end
            S_SQY: r_acc <= mul_p[31:0];
            S_SQS: begin
                r_nxm   <= '0;
                r_nym   <= '0;
                r_dist  <= '0;
                r_found <= 1'b0;
            end
            S_SQRT: if (du_done) r_len <= du_quo[15:0];
            S_DNX:  if (du_done) r_nxm <= du_quo[14:0];
            S_DNY:  if (du_done) r_nym <= du_quo[14:0];
            S_DUX:  if (du_done) r_ux <= (r_nxm == 15'd0) ? 32'hFFFF_FFFF : {1'b0, du_quo};
            S_DUY:  if (du_done) r_uy <= (r_nym == 15'd0) ? 32'hFFFF_FFFF : {1'b0, du_quo};
            S_DCY: begin
                r_cx <= $signed(CRD_W'(cqx)) - $signed(CRD_W'(BIASX));
                r_ox <= remx[OXW-1:0];
            end
            S_FX: begin
                r_cy <= $signed(CRD_W'(cqy)) - $signed(CRD_W'(BIASY));
                r_oy <= remy[OYW-1:0];
            end
            S_FY: r_lx <= LEN_W'(mul_p >> 8);
            S_FL: begin
                r_ly    <= LEN_W'(mul_p >> 8);
                r_dist  <= '0;
                r_found <= 1'b0;
            end
            S_STEP: begin
                r_cx    <= n_cx;
                r_ox    <= n_ox;
                r_cy    <= n_cy;
                r_oy    <= n_oy;
                r_inmap <= n_inmap;
                if (take_x) begin
                    r_dist <= r_lx;
                    r_lx   <= r_lx + LEN_W'(r_ux);
                end else begin
                    r_dist <= r_ly;
                    r_ly   <= r_ly + LEN_W'(r_uy);
                end
            end
            S_CHK: r_found <= hit_now;
            S_HXH: r_hacc <= mul_p;
            S_HYL: r_hx <= f_end(r_sx, nxneg, 51'(r_hacc) + {mul_p[18:0], 32'd0});
            S_HYH: r_hacc <= mul_p;
            S_HYF: r_hy <= f_end(r_sy, nyneg, 51'(r_hacc) + {mul_p[18:0], 32'd0});
            S_OUT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    r_m_tdata <= {r_hy, r_hx};
                    r_m_tuser <= r_found;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    gddrc_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_du),
        .o_done  (du_done),
        .o_quo   (du_quo)
    );

    gddrc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    gddrc_tile_map #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_tile_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (i_s_tdata[97:90]),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .o_clearing (clearing)
    );

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");

    a_dist_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |=> (r_dist >= $past(r_dist)))
        else $error("walk distance went backwards");

    a_du_done_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        du_done |-> (r_state == S_SQRT || r_state == S_DNX || r_state == S_DNY ||
                     r_state == S_DUX || r_state == S_DUY))
        else $error("divider result with no waiting step");

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !s_acc)
        else $error("item taken during map clear");

endmodule

### test/tb_grid_dda_ray_caster_core.sv
// self-checking testbench for the grid dda ray caster core
module tb_grid_dda_ray_caster_core import gddrc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000000;
    localparam int MAP_CELLS   = MAP_COLS_DEF * MAP_ROWS_DEF;

    typedef struct packed {
        logic [23:0] hit_x;
        logic [23:0] hit_y;
        logic        hit_wall;
    } t_hit;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [103:0] i_s_tdata;
    logic [0:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [47:0]  o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    logic [7:0]   tile_map [MAP_CELLS];
    logic [7:0]   wall_sel;
    logic [15:0]  dist_limit;
    t_hit         hits_pending [$];
    int           src_idle_pct;
    int           snk_idle_pct;
    int           fail_count;
    int           stall_cycles;
    int           n_casts;
    int           n_writes;
    int           n_hits;

    grid_dda_ray_caster_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint floor_div(longint p, longint d);
        if (p >= 0) return p / d;
        return -((-p + d - 1) / d);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint round_q22(longint v);
        longint unsigned half;
        longint unsigned m;
        half = 64'd1 << 21;
        if (v >= 0) return longint'((longint'(v) + half) >> 22);
        m = -v;
        if (m <= half) return 0;
        m = m - half;
        return -longint'((m + (64'd1 << 22) - 1) >> 22);
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > 8388607) return 24'h7FFFFF;
        if (v < -8388608) return 24'h800000;
        return v[23:0];
    endfunction

    function automatic longint unit_len(longint n);
        if (n == 0) return 64'hFFFFFFFF;
        return (64'd1 << 30) / (n < 0 ? -n : n);
    endfunction

    function automatic longint norm_dir(longint d, longint unsigned mag);
        longint q;
        q = ((d < 0 ? -d : d) << 14) / mag;
        return d < 0 ? -q : q;
    endfunction

    function automatic bit wall_at(longint px, longint py);
        longint cx;
        longint cy;
        cx = floor_div(px, TILE_WIDTH_DEF);
        cy = floor_div(py, TILE_HEIGHT_DEF);
        if (cx < 0 || cx >= MAP_COLS_DEF || cy < 0 || cy >= MAP_ROWS_DEF) return 1'b0;
        return tile_map[cy * MAP_COLS_DEF + cx] == wall_sel;
    endfunction

    function automatic t_hit trace_ray(logic signed [23:0] sx, logic signed [23:0] sy,
                                       logic signed [15:0] dx, logic signed [15:0] dy);
        t_hit r;
        longint unsigned mag;
        longint nx, ny, ux, uy, px, py, lx, ly, walk, lim;
        bit found;
        r.hit_x = sx;
        r.hit_y = sy;
        r.hit_wall = 1'b0;
        found = 1'b0;
        mag = root_floor(longint'(dx) * dx + longint'(dy) * dy);
        if (mag != 0) begin
            nx = norm_dir(dx, mag);
            ny = norm_dir(dy, mag);
            ux = unit_len(nx);
            uy = unit_len(ny);
            px = floor_div(sx, 256);
            py = floor_div(sy, 256);
            lx = ((nx < 0 ? longint'(sx[7:0]) : 256 - sx[7:0]) * ux) >> 8;
            ly = ((ny < 0 ? longint'(sy[7:0]) : 256 - sy[7:0]) * uy) >> 8;
            walk = 0;
            lim = longint'(dist_limit) << 16;
            while (!found && walk < lim) begin
                if (lx < ly) begin
                    px = px + (nx < 0 ? -1 : 1);
                    walk = lx;
                    lx = lx + ux;
                end else begin
                    py = py + (ny < 0 ? -1 : 1);
                    walk = ly;
                    ly = ly + uy;
                end
                found = wall_at(px, py);
            end
            r.hit_x = clamp24(longint'(sx) + round_q22(nx * walk));
            r.hit_y = clamp24(longint'(sy) + round_q22(ny * walk));
            r.hit_wall = found;
        end
        return r;
    endfunction

    task automatic send_item(logic kind, logic [23:0] sx, logic [23:0] sy, logic [15:0] dx,
                             logic [15:0] dy, logic [4:0] col, logic [4:0] row,
                             logic [7:0] val);
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {6'd0, val, row, col, dy, dx, sy, sx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (kind == REQ_CAST) begin
            hits_pending.push_back(trace_ray(sx, sy, dx, dy));
            n_casts++;
        end else begin
            tile_map[row * MAP_COLS_DEF + col] = val;
            n_writes++;
        end
    endtask

    task automatic cast(logic [23:0] sx, logic [23:0] sy, logic [15:0] dx, logic [15:0] dy);
        send_item(REQ_CAST, sx, sy, dx, dy, $urandom, $urandom, $urandom);
    endtask

    task automatic put_tile(logic [4:0] col, logic [4:0] row, logic [7:0] val);
        send_item(REQ_WRITE, $urandom, $urandom, $urandom, $urandom, col, row, val);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hits_pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WALL_CODE) wall_sel = value[7:0];
        else dist_limit = value[15:0];
    endtask

    task automatic set_limits(logic [7:0] wc, logic [15:0] md);
        drain();
        reg_write(REG_WALL_CODE, {24'd0, wc});
        reg_write(REG_MAX_DIST, {16'd0, md});
    endtask

    task automatic test_directed();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        cast(24'd1000, 24'd1000, 16'd0, 16'd0);
        cast(24'd5000, 24'd6000, 16'd16384, 16'd0);
        set_limits(8'd1, 16'd1);
        cast(24'h7FFFFF, 24'h800000, 16'h8000, 16'h7FFF);
        cast(24'h800000, 24'h7FFFFF, 16'h7FFF, 16'h8000);
        set_limits(8'd1, 16'd0);
        cast(24'd2000, 24'd2000, 16'd300, 16'd200);
        set_limits(8'd7, 16'd300);
        put_tile(5'd0, 5'd0, 8'd7);
        put_tile(5'd31, 5'd31, 8'd7);
        put_tile(5'd3, 5'd1, 8'hFF);
        put_tile(5'd10, 5'd10, 8'd7);
        cast(24'h00C080, 24'h0080FF, 16'd16384, 16'd0);
        cast(24'h00C080, 24'h0080FF, -16'sd16384, 16'd0);
        cast(24'h00C080, 24'h0080FF, 16'd0, 16'd16384);
        cast(24'h00C080, 24'h0080FF, 16'd0, -16'sd16384);
        cast(24'h00A000, 24'h00A000, 16'd1000, 16'd1000);
        cast(24'h00A000, 24'h00A000, -16'sd1, 16'd1);
        cast(24'hFFF000, 24'hFFF000, 16'd20, 16'd20);
        set_limits(8'd0, 16'd100);
        cast(24'd4000, 24'd4000, 16'd5, 16'h8000);
        set_limits(8'hFF, 16'hFFFF);
        cast(24'h00C080, 24'h003080, 16'd16384, 16'd0);
        cast(24'h001000, 24'h001000, 16'd16384, 16'd0);
    endtask

    task automatic test_random(int n_items, int sidle, int kidle, logic [15:0] md);
        logic [7:0]  wc;
        logic [23:0] sx, sy;
        wc = $urandom;
        set_limits(wc, md);
        src_idle_pct = sidle;
        snk_idle_pct = kidle;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 35) begin
                put_tile($urandom, $urandom, ($urandom_range(99) < 70) ? wc : 8'($urandom));
            end else begin
                if ($urandom_range(99) < 10) begin
                    sx = $urandom;
                    sy = $urandom;
                end else begin
                    sx = $urandom_range(24'h80000);
                    sy = $urandom_range(24'h80000);
                end
                cast(sx, sy, $urandom, ($urandom_range(99) < 5) ? 16'd0 : 16'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
            if (o_m_tvalid && i_m_tready) begin
                if (hits_pending.size() == 0) begin
                    $error("result with none expected: %h %b", o_m_tdata, o_m_tuser);
                    fail_count++;
                end else begin
                    t_hit e;
                    e = hits_pending.pop_front();
                    if (e.hit_wall) n_hits++;
                    if (o_m_tdata[23:0] !== e.hit_x) begin
                        $error("hit_x expected %h got %h", e.hit_x, o_m_tdata[23:0]);
                        fail_count++;
                    end
                    if (o_m_tdata[47:24] !== e.hit_y) begin
                        $error("hit_y expected %h got %h", e.hit_y, o_m_tdata[47:24]);
                        fail_count++;
                    end
                    if (o_m_tuser[0] !== e.hit_wall) begin
                        $error("hit_wall expected %b got %b", e.hit_wall, o_m_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        i_m_tready = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        stall_cycles = 0;
        fail_count = 0;
        n_casts = 0;
        n_writes = 0;
        n_hits = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        wall_sel   = WALL_CODE_RST;
        dist_limit = MAX_DIST_RST;
        foreach (tile_map[k]) tile_map[k] = 8'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(90, 10, 55, 16'd200);
        test_random(90, 55, 10, 16'd400);
        test_random(90, 0, 0, 16'd150);
        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d casts (%0d wall hits) and %0d tile writes", n_casts, n_hits,
                 n_writes);
        $display("wall codes and walk limits from 0 to full scale, three idle patterns");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
